/* design/tte_pkg.sv */
// Shared types, constants and codes of the ToF tilt estimator.
package tte_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int ECHO_W           = 16;
   localparam int TILT_W           = 17;
   localparam int FRESH_W          = 18;
   localparam int PROD_W           = 34;
   localparam int DIV_W            = 32;
   localparam int DVS_W            = 16;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int REQ_DATA_W       = 64;
   localparam int RSP_DATA_W       = 120;

   localparam logic [15:0] SQRT_START = 16'h8000;
   localparam logic [15:0] TIME_SCALE = 16'd2000;
   localparam logic [9:0]  WEIGHT_ONE = 10'd1000;
   localparam logic [9:0]  ALPHA_RST  = 10'd500;
   localparam logic [9:0]  SPEED_RST  = 10'd343;

   // Reciprocal of 1000 scaled by 2**36; exact for dividends below 2**26.
   localparam logic [26:0] RECIP_1000  = 27'd68719477;
   localparam int          RECIP_SHIFT = 36;

   localparam int FLAG_TIME  = 0;
   localparam int FLAG_RANGE = 1;
   localparam int FLAG_PLANE = 2;

   typedef enum logic [2:0] {
      CSR_ALPHA,
      CSR_FLAGS,
      CSR_SPEED_L,
      CSR_SPEED_R,
      CSR_SPEED_U,
      CSR_SPEED_D,
      CSR_SPACING,
      CSR_GAIN
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_TIME,
      PH_RANGE,
      PH_HEIGHT,
      PH_TX,
      PH_TY
   } phase_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_TIME_FRESH,
      OP_STORE_FRESH,
      OP_BL_MUL1,
      OP_BL_MUL2,
      OP_DIV_BLEND,
      OP_STORE_BLEND,
      OP_D_MUL,
      OP_D_DIV,
      OP_D_TAKE,
      OP_H_SUM,
      OP_X_DIFF,
      OP_SQ1,
      OP_SQ2,
      OP_SQRT_START,
      OP_TL_CHECK,
      OP_TL_MUL,
      OP_TL_DIV,
      OP_TL_TAKE,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      phase_type  phase;
      logic [1:0] idx;
      logic       axis;
   } dp_cmd_type;

   typedef struct packed {
      logic       div_busy;
      logic       sqrt_busy;
      logic       root_zero;
      logic       out_busy;
      logic [2:0] flags;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_TIME,
      S_STORE,
      S_BL1,
      S_BL2,
      S_BLD,
      S_BLW,
      S_DMUL,
      S_DDIV,
      S_DWAIT,
      S_HSUM,
      S_XDIFF,
      S_SQ1,
      S_SQ2,
      S_SQST,
      S_SQW,
      S_TCHK,
      S_TMUL,
      S_TDIV,
      S_TWAIT,
      S_OUT
   } state_type;

endpackage

/* design/tte_datapath.sv */
// Datapath of the ToF tilt estimator: registers, multiplier, divider and square root.
module tte_datapath #(
   parameter int SAMPLE_WIDTH = tte_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tte_pkg::CSR_IDX_W-1:0]       csr_wr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  logic [tte_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  tte_pkg::dp_cmd_type                 cmd,
   output tte_pkg::dp_stat_type                stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tte_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [9:0]  alpha_ff;
   logic [2:0]  flags_ff;
   logic [9:0]  speed_ff [4];
   logic [31:0] spacing_ff;
   logic [31:0] gain_ff;

   logic [15:0]        in_ff    [4];
   logic [15:0]        time_ff  [4];
   logic [15:0]        range_ff [4];
   logic signed [16:0] plane_ff [3];

   logic signed [17:0] fresh_ff;
   logic signed [33:0] prod_ff;
   logic [15:0]        h_ff;
   logic               tneg_ff;
   logic               bneg_ff;
   logic [1:0]         deg_ff;

   logic        div_busy_ff;
   logic [4:0]  div_cnt_ff;
   logic [31:0] dq_ff;
   logic [15:0] drem_ff;
   logic [15:0] dvs_ff;

   logic        sq_busy_ff;
   logic [15:0] g_ff;
   logic [15:0] c_ff;
   logic [31:0] n_ff;

   logic                                rsp_valid_ff;
   logic [tte_pkg::RSP_DATA_W-1:0]      rsp_data_ff;

   logic [9:0]         w;
   logic [9:0]         wc;
   logic [15:0]        base;
   logic [15:0]        gain;
   logic signed [17:0] prev;
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] mul_p;
   logic               mul_en;
   logic               acc_en;
   logic signed [33:0] prod_in;
   logic [33:0]        pmag;
   logic               div_start;
   logic               rc_start;
   logic [25:0]        rc_x;
   logic [52:0]        rc_p;
   logic [16:0]        trial;
   logic [16:0]        tdiff;
   logic               ge;
   logic [31:0]        gsq;
   logic [15:0]        g_try;
   logic [15:0]        c_nxt;
   logic signed [17:0] quo;
   logic signed [17:0] store_val;
   logic [17:0]        rsum;
   logic [15:0]        da;
   logic [15:0]        db;

   assign w    = (alpha_ff > tte_pkg::WEIGHT_ONE) ? tte_pkg::WEIGHT_ONE : alpha_ff;
   assign wc   = tte_pkg::WEIGHT_ONE - w;
   assign base = cmd.axis ? spacing_ff[31:16] : spacing_ff[15:0];
   assign gain = cmd.axis ? gain_ff[31:16] : gain_ff[15:0];
   assign da   = cmd.axis ? range_ff[2] : range_ff[0];
   assign db   = cmd.axis ? range_ff[3] : range_ff[1];
   assign quo  = dq_ff[17:0];
   assign rsum = 18'(range_ff[0]) + 18'(range_ff[1]) + 18'(range_ff[2]) + 18'(range_ff[3]);

   always_comb begin
      case (cmd.phase)
         tte_pkg::PH_TIME:   prev = {2'b00, time_ff[cmd.idx]};
         tte_pkg::PH_RANGE:  prev = {2'b00, range_ff[cmd.idx]};
         tte_pkg::PH_HEIGHT: prev = {plane_ff[2][16], plane_ff[2]};
         tte_pkg::PH_TX:     prev = {plane_ff[0][16], plane_ff[0]};
         tte_pkg::PH_TY:     prev = {plane_ff[1][16], plane_ff[1]};
         default:            prev = '0;
      endcase
   end

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      acc_en = 1'b0;
      case (cmd.op)
         tte_pkg::OP_BL_MUL1: begin
            mul_a  = {8'd0, w};
            mul_b  = fresh_ff;
            mul_en = 1'b1;
         end
         tte_pkg::OP_BL_MUL2: begin
            mul_a  = {8'd0, wc};
            mul_b  = prev;
            mul_en = 1'b1;
            acc_en = 1'b1;
         end
         tte_pkg::OP_D_MUL: begin
            mul_a  = {2'b00, time_ff[cmd.idx]};
            mul_b  = {8'd0, speed_ff[cmd.idx]};
            mul_en = 1'b1;
         end
         tte_pkg::OP_SQ1: begin
            mul_a  = {2'b00, base};
            mul_b  = {2'b00, base};
            mul_en = 1'b1;
         end
         tte_pkg::OP_SQ2: begin
            mul_a  = {2'b00, h_ff};
            mul_b  = {2'b00, h_ff};
            mul_en = 1'b1;
            acc_en = 1'b1;
         end
         tte_pkg::OP_TL_MUL: begin
            mul_a  = {2'b00, gain};
            mul_b  = {2'b00, h_ff};
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = acc_en ? prod_ff + 34'(mul_p) : 34'(mul_p);
   assign pmag    = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);

   // Division by 1000 or 2000 uses a reciprocal product; 2000 is a halving first.
   assign div_start = (cmd.op == tte_pkg::OP_TL_DIV);
   assign rc_start  = (cmd.op == tte_pkg::OP_DIV_BLEND) || (cmd.op == tte_pkg::OP_D_DIV);
   assign rc_x      = (cmd.op == tte_pkg::OP_D_DIV) ? pmag[26:1] : pmag[25:0];
   assign rc_p      = rc_x * tte_pkg::RECIP_1000;

   assign trial = {drem_ff, dq_ff[31]};
   assign tdiff = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   assign gsq   = g_ff * g_ff;
   assign g_try = (gsq > n_ff) ? (g_ff ^ c_ff) : g_ff;
   assign c_nxt = c_ff >> 1;

   assign store_val = (cmd.op == tte_pkg::OP_STORE_FRESH) ? fresh_ff
                    : (bneg_ff ? -quo : quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= tte_pkg::ALPHA_RST;
         flags_ff    <= '0;
         speed_ff[0] <= tte_pkg::SPEED_RST;
         speed_ff[1] <= tte_pkg::SPEED_RST;
         speed_ff[2] <= tte_pkg::SPEED_RST;
         speed_ff[3] <= tte_pkg::SPEED_RST;
         spacing_ff  <= '0;
         gain_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (tte_pkg::csr_idx_type'(csr_wr_index))
            tte_pkg::CSR_ALPHA:   alpha_ff    <= csr_wr_data[9:0];
            tte_pkg::CSR_FLAGS:   flags_ff    <= csr_wr_data[2:0];
            tte_pkg::CSR_SPEED_L: speed_ff[0] <= csr_wr_data[9:0];
            tte_pkg::CSR_SPEED_R: speed_ff[1] <= csr_wr_data[9:0];
            tte_pkg::CSR_SPEED_U: speed_ff[2] <= csr_wr_data[9:0];
            tte_pkg::CSR_SPEED_D: speed_ff[3] <= csr_wr_data[9:0];
            tte_pkg::CSR_SPACING: spacing_ff  <= csr_wr_data;
            tte_pkg::CSR_GAIN:    gain_ff     <= csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            time_ff[i]  <= '0;
            range_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            plane_ff[i] <= '0;
         end
      end else if ((cmd.op == tte_pkg::OP_STORE_FRESH) ||
                   (cmd.op == tte_pkg::OP_STORE_BLEND)) begin
         case (cmd.phase)
            tte_pkg::PH_TIME:   time_ff[cmd.idx]  <= store_val[15:0];
            tte_pkg::PH_RANGE:  range_ff[cmd.idx] <= store_val[15:0];
            tte_pkg::PH_HEIGHT: plane_ff[2]       <= store_val[16:0];
            tte_pkg::PH_TX:     plane_ff[0]       <= store_val[16:0];
            tte_pkg::PH_TY:     plane_ff[1]       <= store_val[16:0];
            default:            plane_ff[2]       <= plane_ff[2];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tte_pkg::OP_LOAD) begin
         for (int i = 0; i < 4; i++) begin
            in_ff[i] <= 16'(req_tdata[i*tte_pkg::ECHO_W +: SAMPLE_WIDTH]);
         end
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.op == tte_pkg::OP_DIV_BLEND) begin
         bneg_ff <= prod_ff[33];
      end
      if (cmd.op == tte_pkg::OP_X_DIFF) begin
         h_ff    <= (da > db) ? da - db : db - da;
         tneg_ff <= cmd.axis ? (da > db) : !(da > db);
      end
      case (cmd.op)
         tte_pkg::OP_TIME_FRESH: fresh_ff <= {2'b00, in_ff[cmd.idx]};
         tte_pkg::OP_D_TAKE:     fresh_ff <= quo;
         tte_pkg::OP_H_SUM:      fresh_ff <= {2'b00, rsum[17:2]};
         tte_pkg::OP_TL_CHECK:   if (g_ff == '0) fresh_ff <= '0;
         tte_pkg::OP_TL_TAKE:    fresh_ff <= tneg_ff ? -quo : quo;
         default:                fresh_ff <= fresh_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= '0;
      end else if (cmd.op == tte_pkg::OP_LOAD) begin
         deg_ff <= '0;
      end else if ((cmd.op == tte_pkg::OP_TL_CHECK) && (g_ff == '0)) begin
         deg_ff[cmd.axis] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 5'd1;
         if (div_cnt_ff == 5'(tte_pkg::DIV_W - 1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dq_ff   <= pmag[31:0];
         drem_ff <= '0;
         dvs_ff  <= g_ff;
      end else if (rc_start) begin
         dq_ff   <= 32'(rc_p[tte_pkg::RECIP_SHIFT +: 17]);
      end else if (div_busy_ff) begin
         dq_ff   <= {dq_ff[30:0], ge};
         drem_ff <= ge ? tdiff[15:0] : trial[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (cmd.op == tte_pkg::OP_SQRT_START) begin
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff && (c_nxt == '0)) begin
         sq_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tte_pkg::OP_SQRT_START) begin
         n_ff <= (prod_ff[33:32] != 2'b00) ? '1 : prod_ff[31:0];
         g_ff <= tte_pkg::SQRT_START;
         c_ff <= tte_pkg::SQRT_START;
      end else if (sq_busy_ff) begin
         c_ff <= c_nxt;
         g_ff <= (c_nxt == '0) ? g_try : (g_try | c_nxt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == tte_pkg::OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tte_pkg::OP_OUT) begin
         rsp_data_ff <= {4'd0, deg_ff, plane_ff[2][15:0], plane_ff[1], plane_ff[0],
                         range_ff[3], range_ff[2], range_ff[1], range_ff[0]};
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;
   assign stat.div_busy  = div_busy_ff;
   assign stat.sqrt_busy = sq_busy_ff;
   assign stat.root_zero = (g_ff == '0);
   assign stat.out_busy  = rsp_valid_ff && !rsp_tready;
   assign stat.flags     = flags_ff;

endmodule

/* design/tte_ctrl.sv */
// Sequencer of the ToF tilt estimator.
module tte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tte_pkg::dp_stat_type stat,
   output tte_pkg::dp_cmd_type  cmd
);

   tte_pkg::state_type state_ff, state_in;
   tte_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         idx_ff, idx_in;
   logic               axis_ff, axis_in;

   tte_pkg::state_type aft_state;
   logic [1:0]         aft_idx;
   logic               aft_axis;

   always_comb begin
      aft_state = tte_pkg::S_IDLE;
      aft_idx   = idx_ff;
      aft_axis  = axis_ff;
      case (phase_ff)
         tte_pkg::PH_TIME: aft_state = tte_pkg::S_DMUL;
         tte_pkg::PH_RANGE: begin
            if (idx_ff == 2'd3) begin
               aft_state = tte_pkg::S_HSUM;
            end else begin
               aft_state = tte_pkg::S_TIME;
               aft_idx   = idx_ff + 2'd1;
            end
         end
         tte_pkg::PH_HEIGHT: begin
            aft_state = tte_pkg::S_XDIFF;
            aft_axis  = 1'b0;
         end
         tte_pkg::PH_TX: begin
            aft_state = tte_pkg::S_XDIFF;
            aft_axis  = 1'b1;
         end
         tte_pkg::PH_TY: aft_state = tte_pkg::S_OUT;
         default:        aft_state = tte_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         tte_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = tte_pkg::S_TIME;
               idx_in   = 2'd0;
            end
         end
         tte_pkg::S_TIME: begin
            phase_in = tte_pkg::PH_TIME;
            state_in = stat.flags[tte_pkg::FLAG_TIME] ? tte_pkg::S_BL1 : tte_pkg::S_STORE;
         end
         tte_pkg::S_STORE: begin
            state_in = aft_state;
            idx_in   = aft_idx;
            axis_in  = aft_axis;
         end
         tte_pkg::S_BL1: state_in = tte_pkg::S_BL2;
         tte_pkg::S_BL2: state_in = tte_pkg::S_BLD;
         tte_pkg::S_BLD: state_in = tte_pkg::S_BLW;
         tte_pkg::S_BLW: begin
            if (!stat.div_busy) begin
               state_in = aft_state;
               idx_in   = aft_idx;
               axis_in  = aft_axis;
            end
         end
         tte_pkg::S_DMUL: state_in = tte_pkg::S_DDIV;
         tte_pkg::S_DDIV: state_in = tte_pkg::S_DWAIT;
         tte_pkg::S_DWAIT: begin
            if (!stat.div_busy) begin
               phase_in = tte_pkg::PH_RANGE;
               state_in = stat.flags[tte_pkg::FLAG_RANGE] ? tte_pkg::S_BL1
                                                          : tte_pkg::S_STORE;
            end
         end
         tte_pkg::S_HSUM: begin
            phase_in = tte_pkg::PH_HEIGHT;
            state_in = stat.flags[tte_pkg::FLAG_PLANE] ? tte_pkg::S_BL1 : tte_pkg::S_STORE;
         end
         tte_pkg::S_XDIFF: begin
            phase_in = axis_ff ? tte_pkg::PH_TY : tte_pkg::PH_TX;
            state_in = tte_pkg::S_SQ1;
         end
         tte_pkg::S_SQ1:  state_in = tte_pkg::S_SQ2;
         tte_pkg::S_SQ2:  state_in = tte_pkg::S_SQST;
         tte_pkg::S_SQST: state_in = tte_pkg::S_SQW;
         tte_pkg::S_SQW: begin
            if (!stat.sqrt_busy) begin
               state_in = tte_pkg::S_TCHK;
            end
         end
         tte_pkg::S_TCHK: begin
            if (stat.root_zero) begin
               state_in = stat.flags[tte_pkg::FLAG_PLANE] ? tte_pkg::S_BL1
                                                          : tte_pkg::S_STORE;
            end else begin
               state_in = tte_pkg::S_TMUL;
            end
         end
         tte_pkg::S_TMUL: state_in = tte_pkg::S_TDIV;
         tte_pkg::S_TDIV: state_in = tte_pkg::S_TWAIT;
         tte_pkg::S_TWAIT: begin
            if (!stat.div_busy) begin
               state_in = stat.flags[tte_pkg::FLAG_PLANE] ? tte_pkg::S_BL1
                                                          : tte_pkg::S_STORE;
            end
         end
         tte_pkg::S_OUT: begin
            if (!stat.out_busy) begin
               state_in = tte_pkg::S_IDLE;
            end
         end
         default: state_in = tte_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = tte_pkg::OP_NONE;
      cmd.phase  = phase_ff;
      cmd.idx    = idx_ff;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         tte_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = tte_pkg::OP_LOAD;
         end
         tte_pkg::S_TIME:  cmd.op = tte_pkg::OP_TIME_FRESH;
         tte_pkg::S_STORE: cmd.op = tte_pkg::OP_STORE_FRESH;
         tte_pkg::S_BL1:   cmd.op = tte_pkg::OP_BL_MUL1;
         tte_pkg::S_BL2:   cmd.op = tte_pkg::OP_BL_MUL2;
         tte_pkg::S_BLD:   cmd.op = tte_pkg::OP_DIV_BLEND;
         tte_pkg::S_BLW:   if (!stat.div_busy) cmd.op = tte_pkg::OP_STORE_BLEND;
         tte_pkg::S_DMUL:  cmd.op = tte_pkg::OP_D_MUL;
         tte_pkg::S_DDIV:  cmd.op = tte_pkg::OP_D_DIV;
         tte_pkg::S_DWAIT: if (!stat.div_busy) cmd.op = tte_pkg::OP_D_TAKE;
         tte_pkg::S_HSUM:  cmd.op = tte_pkg::OP_H_SUM;
         tte_pkg::S_XDIFF: cmd.op = tte_pkg::OP_X_DIFF;
         tte_pkg::S_SQ1:   cmd.op = tte_pkg::OP_SQ1;
         tte_pkg::S_SQ2:   cmd.op = tte_pkg::OP_SQ2;
         tte_pkg::S_SQST:  cmd.op = tte_pkg::OP_SQRT_START;
         tte_pkg::S_SQW:   cmd.op = tte_pkg::OP_NONE;
         tte_pkg::S_TCHK:  cmd.op = tte_pkg::OP_TL_CHECK;
         tte_pkg::S_TMUL:  cmd.op = tte_pkg::OP_TL_MUL;
         tte_pkg::S_TDIV:  cmd.op = tte_pkg::OP_TL_DIV;
         tte_pkg::S_TWAIT: if (!stat.div_busy) cmd.op = tte_pkg::OP_TL_TAKE;
         tte_pkg::S_OUT:   if (!stat.out_busy) cmd.op = tte_pkg::OP_OUT;
         default:          cmd.op = tte_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tte_pkg::S_IDLE;
         phase_ff <= tte_pkg::PH_TIME;
         idx_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

/* design/tof_tilt_estimator.sv */
// Top level of the ToF tilt estimator: sequencer and datapath.
// One reading is taken at a time and yields one result beat after it is accepted; the time
// to that beat is set by the radix-2 divider of the tilt quotients, two 16-step square roots
// and the filters, plus any time the output is held off. An axis whose hypotenuse is zero
// skips its quotient. A new reading is accepted in the cycle after the result has been
// loaded into the output register.
module tof_tilt_estimator #(
   parameter int SAMPLE_WIDTH = tte_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tte_pkg::CSR_IDX_W-1:0]   csr_wr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // echo_left, echo_right, echo_up, echo_down
   input  logic [tte_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // range_left, range_right, range_up, range_down, tilt_x, tilt_y, height, degenerate
   output logic [tte_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   tte_pkg::dp_cmd_type  cmd;
   tte_pkg::dp_stat_type stat;

   tte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tte_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_index (csr_wr_index),
      .csr_wr_data  (csr_wr_data),
      .req_tdata    (req_tdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

/* design/tte_checker.sv */
// Port-level assertions of the ToF tilt estimator and their bind.
module tte_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tte_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("reading accepted while previous one still in work");

   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result shown without the input side being freed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the handshake state");

endmodule

bind tof_tilt_estimator tte_checker u_tte_checker (.*);

/* tb/tb_tof_tilt_estimator.sv */
// Self-checking testbench of the ToF tilt estimator: directed table, then random readings.
`timescale 1ns / 100ps

module tb_tof_tilt_estimator;

   localparam int  HALF_PERIOD = 4;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam int  HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [15:0] down;
      logic [15:0] up;
      logic [15:0] right;
      logic [15:0] left;
   } reading_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic [1:0]         degenerate;
      logic [15:0]        height;
      logic signed [16:0] tilt_y;
      logic signed [16:0] tilt_x;
      logic [15:0]        range_down;
      logic [15:0]        range_up;
      logic [15:0]        range_right;
      logic [15:0]        range_left;
   } pose_type;

   typedef struct {
      int          phase;
      reading_type rd;
      bit          typed;
      pose_type    pose;
   } vector_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [tte_pkg::CSR_IDX_W-1:0]   csr_wr_index;
   logic [tte_pkg::CSR_DATA_W-1:0]  csr_wr_data;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [tte_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [tte_pkg::RSP_DATA_W-1:0]  rsp_tdata;

   longint  alpha_q, flags_q, spacing_q, gain_q;
   longint  speed_q[4];
   longint  time_st[4];
   longint  range_st[4];
   longint  plane_st[3];
   pose_type pending_poses[$];
   int      errors;
   int      cycles;
   bit      hold_req;
   bit      no_idle;

   tof_tilt_estimator u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_index (csr_wr_index),
      .csr_wr_data  (csr_wr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_tof_tilt_estimator NOT OK");
         $finish;
      end
   end

   function automatic longint blend(longint fresh, longint prev);
      longint w;
      w = (alpha_q > 1000) ? 1000 : alpha_q;
      return (w * fresh + (1000 - w) * prev) / 1000;
   endfunction

   function automatic longint floor_root(longint n);
      longint r;
      longint t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic longint tilt_magnitude(longint base, longint diff, longint gain,
                                             output bit zero);
      longint sum;
      longint hyp;
      sum = base * base + diff * diff;
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      hyp = floor_root(sum);
      zero = (hyp == 0);
      return zero ? 0 : (gain * diff) / hyp;
   endfunction

   function automatic pose_type estimate_pose(reading_type rd);
      pose_type p;
      longint   echo[4];
      longint   range_raw;
      longint   t;
      longint   mean;
      bit       zx, zy;
      echo = '{rd.left, rd.right, rd.up, rd.down};
      for (int i = 0; i < 4; i++) begin
         if (flags_q[tte_pkg::FLAG_TIME]) time_st[i] = blend(echo[i], time_st[i]) & 16'hFFFF;
         else time_st[i] = echo[i];
         range_raw = (time_st[i] * speed_q[i]) / 2000;
         if (flags_q[tte_pkg::FLAG_RANGE])
            range_st[i] = blend(range_raw, range_st[i]) & 16'hFFFF;
         else range_st[i] = range_raw & 16'hFFFF;
      end
      mean = (range_st[0] + range_st[1] + range_st[2] + range_st[3]) / 4;
      plane_st[2] = flags_q[tte_pkg::FLAG_PLANE] ? blend(mean, plane_st[2]) : mean;
      t = tilt_magnitude(spacing_q & 16'hFFFF,
                         (range_st[0] > range_st[1]) ? range_st[0] - range_st[1]
                                                     : range_st[1] - range_st[0],
                         gain_q & 16'hFFFF, zx);
      if (!(range_st[0] > range_st[1])) t = -t;
      plane_st[0] = flags_q[tte_pkg::FLAG_PLANE] ? blend(t, plane_st[0]) : t;
      t = tilt_magnitude(spacing_q >> 16,
                         (range_st[2] > range_st[3]) ? range_st[2] - range_st[3]
                                                     : range_st[3] - range_st[2],
                         gain_q >> 16, zy);
      if (range_st[2] > range_st[3]) t = -t;
      plane_st[1] = flags_q[tte_pkg::FLAG_PLANE] ? blend(t, plane_st[1]) : t;
      p = '0;
      p.range_left  = range_st[0][15:0];
      p.range_right = range_st[1][15:0];
      p.range_up    = range_st[2][15:0];
      p.range_down  = range_st[3][15:0];
      p.tilt_x      = plane_st[0][16:0];
      p.tilt_y      = plane_st[1][16:0];
      p.height      = plane_st[2][15:0];
      p.degenerate  = {zy, zx};
      return p;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
   endtask

   always @(posedge clock) begin
      pose_type got;
      pose_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_poses.size() == 0) begin
            report("unexpected result beat", 1, 0);
         end else begin
            want = pending_poses.pop_front();
            if (got.range_left  !== want.range_left)
               report("range_left", got.range_left, want.range_left);
            if (got.range_right !== want.range_right)
               report("range_right", got.range_right, want.range_right);
            if (got.range_up    !== want.range_up)
               report("range_up", got.range_up, want.range_up);
            if (got.range_down  !== want.range_down)
               report("range_down", got.range_down, want.range_down);
            if (got.tilt_x      !== want.tilt_x)
               report("tilt_x", got.tilt_x, want.tilt_x);
            if (got.tilt_y      !== want.tilt_y)
               report("tilt_y", got.tilt_y, want.tilt_y);
            if (got.height      !== want.height)
               report("height", got.height, want.height);
            if (got.degenerate  !== want.degenerate)
               report("degenerate", got.degenerate, want.degenerate);
         end
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            n = idle_length();
            if (n == 0) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 8)) @(negedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (n) @(negedge clock);
            end
         end
      end
   end

   task automatic write_register(tte_pkg::csr_idx_type idx, longint value);
      csr_wr_en    <= 1'b1;
      csr_wr_index <= idx;
      csr_wr_data  <= value[31:0];
      case (idx)
         tte_pkg::CSR_ALPHA:   alpha_q    = value & 10'h3FF;
         tte_pkg::CSR_FLAGS:   flags_q    = value & 3'h7;
         tte_pkg::CSR_SPEED_L: speed_q[0] = value & 10'h3FF;
         tte_pkg::CSR_SPEED_R: speed_q[1] = value & 10'h3FF;
         tte_pkg::CSR_SPEED_U: speed_q[2] = value & 10'h3FF;
         tte_pkg::CSR_SPEED_D: speed_q[3] = value & 10'h3FF;
         tte_pkg::CSR_SPACING: spacing_q  = value & 32'hFFFF_FFFF;
         tte_pkg::CSR_GAIN:    gain_q     = value & 32'hFFFF_FFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_all(longint alpha, longint flags, longint spd, longint spacing,
                            longint gain);
      write_register(tte_pkg::CSR_ALPHA, alpha);
      write_register(tte_pkg::CSR_FLAGS, flags);
      write_register(tte_pkg::CSR_SPEED_L, spd);
      write_register(tte_pkg::CSR_SPEED_R, spd);
      write_register(tte_pkg::CSR_SPEED_U, spd);
      write_register(tte_pkg::CSR_SPEED_D, spd);
      write_register(tte_pkg::CSR_SPACING, spacing);
      write_register(tte_pkg::CSR_GAIN, gain);
   endtask

   task automatic send_reading(reading_type rd, bit typed, pose_type pose);
      int gap;
      pose_type p;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rd;
      do @(posedge clock); while (!req_tready);
      p = estimate_pose(rd);
      pending_poses.push_back(typed ? pose : p);
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_echo();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic longint random_speed();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1023;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic longint random_pair();
      case ($urandom_range(0, 4))
         0: return 32'hFFFF_FFFF;
         1: return {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   vector_type vectors[$];
   pose_type   z;
   pose_type   full;
   reading_type rd;
   int          last_phase;

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_index = '0;
      csr_wr_data  = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      errors       = 0;
      cycles       = 0;
      hold_req     = 1'b0;
      no_idle      = 1'b0;
      alpha_q      = 500;
      flags_q      = 0;
      speed_q      = '{343, 343, 343, 343};
      spacing_q    = 0;
      gain_q       = 0;
      time_st      = '{0, 0, 0, 0};
      range_st     = '{0, 0, 0, 0};
      plane_st     = '{0, 0, 0};

      z = '0;
      z.degenerate = 2'b11;
      full = '0;
      full.range_left  = 16'd11239;
      full.range_right = 16'd11239;
      full.range_up    = 16'd11239;
      full.range_down  = 16'd11239;
      full.height      = 16'd11239;
      full.degenerate  = 2'b11;
      vectors = '{
         '{0, 64'h0, 1'b1, z},
         '{0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, full},
         '{0, 64'h0000_0000_0000_FFFF, 1'b0, z},
         '{0, 64'hFFFF_0000_0000_0000, 1'b0, z},
         '{1, 64'h0000_0000_0000_FFFF, 1'b0, z},
         '{1, 64'h0000_FFFF_FFFF_0000, 1'b0, z},
         '{1, 64'hFFFF_0000_0000_FFFF, 1'b0, z},
         '{1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, z},
         '{1, 64'h0, 1'b0, z},
         '{1, 64'h8000_0001_7FFF_FFFE, 1'b0, z},
         '{2, 64'h1234_1234_5678_5678, 1'b0, z},
         '{2, 64'h0, 1'b0, z},
         '{2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, z},
         '{3, 64'h0100_0200_0300_0100, 1'b0, z},
         '{3, 64'h0200_0100_0100_0300, 1'b0, z},
         '{3, 64'h00FF_00FF_0000_FFFF, 1'b0, z},
         '{3, 64'h5555_AAAA_AAAA_5555, 1'b0, z},
         '{3, 64'hAAAA_5555_5555_AAAA, 1'b0, z}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      last_phase = 0;
      foreach (vectors[i]) begin
         if (vectors[i].phase != last_phase) begin
            drain();
            case (vectors[i].phase)
               1: write_all(1023, 7, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
               2: begin
                  write_register(tte_pkg::CSR_FLAGS, 4);
                  write_register(tte_pkg::CSR_SPACING, 0);
                  write_register(tte_pkg::CSR_GAIN, 32'h0100_0100);
               end
               default: write_all(0, 0, 1, 32'h0003_0004, 32'h03E8_FFFF);
            endcase
            last_phase = vectors[i].phase;
         end
         send_reading(vectors[i].rd, vectors[i].typed, vectors[i].pose);
      end

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case ($urandom_range(0, 3))
            0: write_register(tte_pkg::CSR_ALPHA, 0);
            1: write_register(tte_pkg::CSR_ALPHA, 1000);
            2: write_register(tte_pkg::CSR_ALPHA, 1023);
            default: write_register(tte_pkg::CSR_ALPHA, $urandom_range(0, 1023));
         endcase
         write_register(tte_pkg::CSR_FLAGS,
                        (ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7));
         write_register(tte_pkg::CSR_SPEED_L, random_speed());
         write_register(tte_pkg::CSR_SPEED_R, random_speed());
         write_register(tte_pkg::CSR_SPEED_U, random_speed());
         write_register(tte_pkg::CSR_SPEED_D, random_speed());
         write_register(tte_pkg::CSR_SPACING, random_pair());
         write_register(tte_pkg::CSR_GAIN, random_pair());
         no_idle = (ph == 3);
         for (int k = 0; k < 100; k++) begin
            if (ph == 5 && k == 10) hold_req = 1'b1;
            rd.left  = random_echo();
            rd.right = ($urandom_range(0, 9) == 0) ? rd.left : random_echo();
            rd.up    = random_echo();
            rd.down  = ($urandom_range(0, 9) == 0) ? rd.up : random_echo();
            send_reading(rd, 1'b0, z);
         end
         no_idle = 1'b0;
      end

      req_tvalid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (700) @(posedge clock);
      if (errors == 0) begin
         $display("tb_tof_tilt_estimator OK");
      end else begin
         $display("tb_tof_tilt_estimator NOT OK");
      end
      $finish;
   end

endmodule
